[hw/rtl/crc_pkg.sv]
// Shared types and constants for the climate relay controller.
package crc_pkg;

   typedef enum logic [1:0] {
      SCR_MAIN = 2'd0,
      SCR_DEV  = 2'd1,
      SCR_SET  = 2'd2
   } screen_type;

   typedef enum logic [1:0] {
      SEL_TEMP_HIGH  = 2'd0,
      SEL_TEMP_LOW   = 2'd1,
      SEL_HUMID_HIGH = 2'd2
   } setting_type;

   localparam logic [2:0] KEY_NONE = 3'd0;
   localparam logic [2:0] KEY_PREV = 3'd1;
   localparam logic [2:0] KEY_NEXT = 3'd2;
   localparam logic [2:0] KEY_DOWN = 3'd3;
   localparam logic [2:0] KEY_UP   = 3'd4;

   localparam logic CSR_VALID_TEMP = 1'b0;
   localparam logic CSR_STARTUP    = 1'b1;

   localparam logic [7:0] RESET_VALID_TEMP = 8'd60;
   localparam logic [7:0] RESET_STARTUP    = 8'd100;
   localparam logic [5:0] RESET_TEMP_HIGH  = 6'd40;
   localparam logic [5:0] RESET_TEMP_LOW   = 6'd25;
   localparam logic [6:0] RESET_HUMID_HIGH = 7'd70;

   localparam logic [5:0] TEMP_HIGH_MIN = 6'd20;
   localparam logic [5:0] TEMP_HIGH_MAX = 6'd50;
   localparam logic [5:0] TEMP_LOW_MIN  = 6'd10;
   localparam logic [6:0] HUMID_MIN     = 7'd30;
   localparam logic [6:0] HUMID_MAX     = 7'd99;
   localparam logic [6:0] LIMIT_GAP     = 7'd5;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   // relay bit positions
   localparam int RLY_HEATER = 0;
   localparam int RLY_COOLER = 1;
   localparam int RLY_FAN    = 2;
   localparam int RLY_MISTER = 3;

   typedef struct packed {
      screen_type  screen;
      logic        manual;
      logic [3:0]  relays;
      logic [5:0]  temp_high;
      logic [5:0]  temp_low;
      logic [6:0]  humid_high;
      setting_type cursor;
   } menu_state_type;

endpackage

[hw/rtl/climate_relay_controller_unit.sv]
// Top level of the climate relay controller: handshake, state and result registers.
//
// Each transfer on the req_ channel is one control cycle: temperature, humidity
// and a debounced key. Every accepted item yields exactly one rsp_ transfer
// carrying the relay drives, menu position, thresholds and the ready flag as
// they stand after that control cycle.
// The item is captured in an input register; once the result register is
// free or being taken, the menu and control logic update the state registers,
// which double as the result register, and the result is then offered.
// One item per cycle is sustained while results are taken; req_ready stays
// high while the result register is empty or being taken in the same cycle.
// If the receiver stalls, the result holds and one further item waits in the
// input register; req_ready then drops until the result is taken.
// Reset clears both valid flags, restores the thresholds and configuration
// registers to their defaults, returns to the main screen in automatic mode
// with all relays off and restarts the startup counter.
// The csr_ port writes valid_temp_limit (index 0) and startup_cycles
// (index 1), with no read-back.
module climate_relay_controller_unit import crc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_temperature,
   input  logic [7:0] req_humidity,
   input  logic [2:0] req_key,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_heater_on,
   output logic       rsp_cooler_on,
   output logic       rsp_fan_on,
   output logic       rsp_mister_on,
   output logic [1:0] rsp_screen,
   output logic       rsp_manual_mode,
   output logic [1:0] rsp_selected_setting,
   output logic [5:0] rsp_temp_high_limit,
   output logic [5:0] rsp_temp_low_limit,
   output logic [6:0] rsp_humid_high_limit,
   output logic       rsp_ready_res,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic           in_vld_ff, in_vld_in;
   logic [7:0]     temp_ff, humid_ff;
   logic [2:0]     key_ff;
   logic           out_vld_ff, out_vld_in;
   logic [7:0]     valid_temp_ff, startup_ff;
   menu_state_type state_ff, state_in;
   menu_state_type menu_nxt;
   logic [7:0]     count_ff, count_in;
   logic           ready_ff, ready_in;
   logic [3:0]     relays_ctrl;
   logic           advance;
   logic           req_xfer;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_vld_in  = req_xfer || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_ready);

   assign count_in = (count_ff < COUNT_MAX) ? count_ff + 8'd1 : count_ff;
   // ready is sticky once set
   assign ready_in = ready_ff || (count_in > startup_ff);

   crc_menu u_menu (
      .cur (state_ff),
      .key (key_ff),
      .nxt (menu_nxt)
   );

   crc_ctrl u_ctrl (
      .relays           (menu_nxt.relays),
      .manual           (menu_nxt.manual),
      .ready            (ready_in),
      .temperature      (temp_ff),
      .humidity         (humid_ff),
      .valid_temp_limit (valid_temp_ff),
      .temp_high        (menu_nxt.temp_high),
      .temp_low         (menu_nxt.temp_low),
      .humid_high       (menu_nxt.humid_high),
      .relays_out       (relays_ctrl)
   );

   always_comb begin
      state_in        = menu_nxt;
      state_in.relays = relays_ctrl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff           <= 1'b0;
         out_vld_ff          <= 1'b0;
         valid_temp_ff       <= RESET_VALID_TEMP;
         startup_ff          <= RESET_STARTUP;
         count_ff            <= 8'd0;
         ready_ff            <= 1'b0;
         state_ff.screen     <= SCR_MAIN;
         state_ff.manual     <= 1'b0;
         state_ff.relays     <= 4'd0;
         state_ff.temp_high  <= RESET_TEMP_HIGH;
         state_ff.temp_low   <= RESET_TEMP_LOW;
         state_ff.humid_high <= RESET_HUMID_HIGH;
         state_ff.cursor     <= SEL_TEMP_HIGH;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) begin
            if (csr_index == CSR_VALID_TEMP) begin
               valid_temp_ff <= csr_wdata;
            end else begin
               startup_ff <= csr_wdata;
            end
         end
         if (advance) begin
            count_ff <= count_in;
            ready_ff <= ready_in;
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         temp_ff  <= req_temperature;
         humid_ff <= req_humidity;
         key_ff   <= req_key;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_heater_on        = state_ff.relays[RLY_HEATER];
   assign rsp_cooler_on        = state_ff.relays[RLY_COOLER];
   assign rsp_fan_on           = state_ff.relays[RLY_FAN];
   assign rsp_mister_on        = state_ff.relays[RLY_MISTER];
   assign rsp_screen           = state_ff.screen;
   assign rsp_manual_mode      = state_ff.manual;
   assign rsp_selected_setting = state_ff.cursor;
   assign rsp_temp_high_limit  = state_ff.temp_high;
   assign rsp_temp_low_limit   = state_ff.temp_low;
   assign rsp_humid_high_limit = state_ff.humid_high;
   assign rsp_ready_res        = ready_ff;

endmodule

[hw/rtl/crc_menu.sv]
// Key handling for the three-screen menu: mode, manual relays and thresholds.
module crc_menu import crc_pkg::*; (
   input  menu_state_type cur,
   input  logic [2:0]     key,
   output menu_state_type nxt
);

   logic [6:0] low_plus_gap;

   assign low_plus_gap = {1'b0, cur.temp_low} + LIMIT_GAP;

   always_comb begin
      nxt = cur;
      case (cur.screen)
         SCR_MAIN: begin
            if (key == KEY_PREV) begin
               nxt.manual = ~cur.manual;
            end else if (key == KEY_NEXT) begin
               nxt.screen = SCR_DEV;
            end
         end
         SCR_DEV: begin
            if (key == KEY_PREV) begin
               nxt.screen = SCR_MAIN;
            end else if (key == KEY_NEXT) begin
               nxt.screen = SCR_SET;
               nxt.cursor = SEL_TEMP_HIGH;
            end else if (key == KEY_DOWN) begin
               // lowest relay that is on goes off
               nxt.relays = cur.relays & (cur.relays - 4'd1);
            end else if (key == KEY_UP) begin
               // lowest relay that is off goes on
               nxt.relays = cur.relays | (cur.relays + 4'd1);
            end
         end
         SCR_SET: begin
            if (key == KEY_PREV) begin
               if (cur.cursor == SEL_TEMP_HIGH) begin
                  nxt.screen = SCR_DEV;
               end else if (cur.cursor == SEL_TEMP_LOW) begin
                  nxt.cursor = SEL_TEMP_HIGH;
               end else begin
                  nxt.cursor = SEL_TEMP_LOW;
               end
            end else if (key == KEY_NEXT) begin
               if (cur.cursor == SEL_TEMP_HIGH) begin
                  nxt.cursor = SEL_TEMP_LOW;
               end else if (cur.cursor == SEL_TEMP_LOW) begin
                  nxt.cursor = SEL_HUMID_HIGH;
               end else begin
                  nxt.screen = SCR_MAIN;
                  nxt.cursor = SEL_TEMP_HIGH;
               end
            end else if (key == KEY_DOWN || key == KEY_UP) begin
               case (cur.cursor)
                  SEL_TEMP_HIGH: begin
                     if (key == KEY_UP && cur.temp_high < TEMP_HIGH_MAX) begin
                        nxt.temp_high = cur.temp_high + 6'd1;
                     end else if (key == KEY_DOWN && cur.temp_high > TEMP_HIGH_MIN) begin
                        nxt.temp_high = cur.temp_high - 6'd1;
                     end
                  end
                  SEL_TEMP_LOW: begin
                     if (key == KEY_UP && low_plus_gap < {1'b0, cur.temp_high}) begin
                        nxt.temp_low = cur.temp_low + 6'd1;
                     end else if (key == KEY_DOWN && cur.temp_low > TEMP_LOW_MIN) begin
                        nxt.temp_low = cur.temp_low - 6'd1;
                     end
                  end
                  SEL_HUMID_HIGH: begin
                     if (key == KEY_UP && cur.humid_high < HUMID_MAX) begin
                        nxt.humid_high = cur.humid_high + 7'd1;
                     end else if (key == KEY_DOWN && cur.humid_high > HUMID_MIN) begin
                        nxt.humid_high = cur.humid_high - 7'd1;
                     end
                  end
                  default: begin
                     nxt.cursor = cur.cursor;
                  end
               endcase
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

[hw/rtl/crc_ctrl.sv]
// Bang-bang control of heater, cooler and fan in automatic mode, with reading validity gating.
module crc_ctrl import crc_pkg::*; (
   input  logic [3:0] relays,
   input  logic       manual,
   input  logic       ready,
   input  logic [7:0] temperature,
   input  logic [7:0] humidity,
   input  logic [7:0] valid_temp_limit,
   input  logic [5:0] temp_high,
   input  logic [5:0] temp_low,
   input  logic [6:0] humid_high,
   output logic [3:0] relays_out
);

   logic reading_bad;

   assign reading_bad = !ready || (temperature == 8'd0) || (temperature > valid_temp_limit);

   always_comb begin
      relays_out = relays;
      if (reading_bad) begin
         relays_out = relays & 4'b1000;
      end else if (!manual) begin
         relays_out = relays & 4'b1000;
         if (temperature < {2'b00, temp_low}) begin
            relays_out[RLY_HEATER] = 1'b1;
         end else if (temperature > {2'b00, temp_high}) begin
            relays_out[RLY_COOLER] = 1'b1;
         end
         if (humidity > {1'b0, humid_high}) begin
            relays_out[RLY_FAN] = 1'b1;
         end
      end
   end

endmodule
